// ----- design/murmur2_32_stream_hash_defines.svh -----
// Assertion macros shared by the murmur2_32_stream_hash RTL.
// Included by the modules that carry assertions; no other dependencies.
`ifndef MURMUR2_32_STREAM_HASH_DEFINES_SVH
`define MURMUR2_32_STREAM_HASH_DEFINES_SVH

`ifndef SYNTH
`define MH2_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mh2 assertion failed");
`define MH2_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("mh2 assertion failed");
`else
`define MH2_ASSERT(lbl, prop)
`define MH2_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// ----- design/mh2_pkg.sv -----
// Types and constants for the 32-bit MurmurHash2 stream hasher.
// No dependencies; used by every other file of the block but the assertion header.
`default_nettype none

package mh2_pkg;

   localparam int WORD_W   = 32;
   localparam int VCNT_W   = 3;
   localparam int LEN_W    = 31;

   localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
   localparam int KEY_SHIFT  = 24;
   localparam int FIN_SHIFT1 = 13;
   localparam int FIN_SHIFT2 = 15;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QUEUE_AW + 1;

   // What the back end does with one word.
   typedef enum logic [1:0] {
      OP_FULL,
      OP_TAIL,
      OP_NONE
   } mh2_op_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_FIN,
      BK_EMIT
   } mh2_bstate_type;

   typedef struct packed {
      mh2_op_type        op;
      logic              last;
      logic              start;
      logic [WORD_W-1:0] start_val;
      logic [WORD_W-1:0] operand;
   } mh2_item_type;

endpackage

`default_nettype wire

// ----- design/mh2_if.sv -----
// Handshake channels of the MurmurHash2 stream hasher: request and response.
// Depends on mh2_pkg for the field widths.
`default_nettype none

interface mh2_req_if;
   logic                          valid;
   logic                          ready;
   logic [mh2_pkg::WORD_W-1:0]    data_word;
   logic [mh2_pkg::VCNT_W-1:0]    valid_bytes;
   logic                          is_last;
   logic [mh2_pkg::LEN_W-1:0]     msg_length;

   modport source (output valid, data_word, valid_bytes, is_last, msg_length,
                   input ready);
   modport sink   (input valid, data_word, valid_bytes, is_last, msg_length,
                   output ready);
endinterface

interface mh2_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mh2_pkg::WORD_W-1:0]    hash_out;

   modport source (output valid, hash_out, input ready);
   modport sink   (input valid, hash_out, output ready);
endinterface

`default_nettype wire

// ----- design/murmur2_32_stream_hash.sv -----
// Top level of the 32-bit MurmurHash2 stream hasher.
// Depends on mh2_pkg, mh2_if, mh2_front, mh2_queue and mh2_back.
//
// A message streams in on req_chan as little-endian 32-bit words, one per
// beat. The first beat of a message starts the hash from the seed register
// XOR msg_length; the beat with is_last set carries 0 to 4 valid bytes and
// closes the message. One hash per message leaves on rsp_chan.
// csr_write_en/csr_write_data load the seed; write it only between messages.
// The last beat passes both front-end stages and the queue, then the back
// end mixes it, runs the avalanche and loads the output register.
// Throughput: the front end takes one beat per cycle while the queue has
// room; the back end's multiply-XOR loop consumes one word per cycle, and the
// end of each message holds it in the avalanche state and the emit state.
// The front end's two-stage key-mix pipeline feeds a four-entry queue; when
// the queue fills, req_chan.ready drops. A stalled rsp_chan holds the hash in
// the output register while the back end keeps working on the next message,
// until a second hash is due.
// Synchronous reset clears the seed to zero, closes any open message and
// empties the pipeline, queue and output register.
`default_nettype none

module murmur2_32_stream_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [mh2_pkg::WORD_W-1:0] csr_write_data,
   mh2_req_if.sink                    req_chan,
   mh2_rsp_if.source                  rsp_chan
);
   import mh2_pkg::*;

   mh2_item_type push_item;
   mh2_item_type head_item;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;

   mh2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req            (req_chan),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   mh2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   mh2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- design/mh2_front.sv -----
// Front end: takes request beats, classifies them and pipelines the key mix.
// Depends on mh2_pkg and the mh2_req_if interface.
`default_nettype none
`include "murmur2_32_stream_hash_defines.svh"

module mh2_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [mh2_pkg::WORD_W-1:0] csr_write_data,
   mh2_req_if.sink                    req,
   input  logic                       q_full,
   output logic                       q_push,
   output mh2_pkg::mh2_item_type      q_item
);
   import mh2_pkg::*;

   logic [WORD_W-1:0] seed_ff;
   logic              open_ff;
   logic              open_in;
   logic              v1_ff;
   logic              v2_ff;
   mh2_item_type      item1_ff;
   mh2_item_type      item1_in;
   mh2_item_type      item2_ff;
   mh2_item_type      item2_in;
   logic              adv;
   logic              accept;
   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] prod1;
   logic [WORD_W-1:0] mix2;
   logic [WORD_W-1:0] prod2;

   always_comb begin
      adv       = !(v2_ff && q_full);
      req.ready = adv;
      accept    = req.valid && adv;
      q_push    = v2_ff && adv;
      q_item    = item2_ff;

      unique case (req.valid_bytes[1:0])
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         2'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = '0;
      endcase

      prod1 = req.data_word * MIX_MUL;

      item1_in.last      = req.is_last;
      item1_in.start     = !open_ff;
      item1_in.start_val = seed_ff ^ {1'b0, req.msg_length};
      // Counts above four act as a full word.
      priority if (!req.is_last || req.valid_bytes[2]) begin
         item1_in.op      = OP_FULL;
         item1_in.operand = prod1;
      end else if (req.valid_bytes[1:0] == 2'd0) begin
         item1_in.op      = OP_NONE;
         item1_in.operand = '0;
      end else begin
         item1_in.op      = OP_TAIL;
         item1_in.operand = req.data_word & tail_mask;
      end

      mix2  = item1_ff.operand ^ (item1_ff.operand >> KEY_SHIFT);
      prod2 = mix2 * MIX_MUL;
      item2_in = item1_ff;
      if (item1_ff.op == OP_FULL) begin
         item2_in.operand = prod2;
      end

      open_in = accept ? !req.is_last : open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         open_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            seed_ff <= csr_write_data;
         end
         open_ff <= open_in;
         if (adv) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item1_ff <= item1_in;
         item2_ff <= item2_in;
      end
   end

   `MH2_ASSERT_NEXT(a_front_shift, adv && v1_ff, v2_ff)

endmodule

`default_nettype wire

// ----- design/mh2_queue.sv -----
// Short queue between the front end and the back end of the hasher.
// Depends on mh2_pkg for the item type and depth.
`default_nettype none
`include "murmur2_32_stream_hash_defines.svh"

module mh2_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mh2_pkg::mh2_item_type push_item,
   input  logic                  pop,
   output mh2_pkg::mh2_item_type head_item,
   output logic                  full,
   output logic                  empty
);
   import mh2_pkg::*;

   mh2_item_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff;
   logic [QUEUE_AW-1:0] rptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic [QCNT_W-1:0]   cnt_in;

   always_comb begin
      full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      empty     = (cnt_ff == '0);
      head_item = mem_ff[rptr_ff];
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

   `MH2_ASSERT(a_queue_no_overflow, !(push && full && !pop))
   `MH2_ASSERT(a_queue_no_underflow, !(pop && empty))

endmodule

`default_nettype wire

// ----- design/mh2_back.sv -----
// Back end: runs the h*m ^ k loop, the tail step and the final avalanche.
// Depends on mh2_pkg and the mh2_rsp_if interface.
`default_nettype none
`include "murmur2_32_stream_hash_defines.svh"

module mh2_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mh2_pkg::mh2_item_type head_item,
   input  logic                  q_empty,
   output logic                  q_pop,
   mh2_rsp_if.source             rsp
);
   import mh2_pkg::*;

   mh2_bstate_type    state_ff;
   mh2_bstate_type    state_in;
   logic [WORD_W-1:0] h_ff;
   logic [WORD_W-1:0] h_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_hash_ff;
   logic              out_load;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] tail_x;
   logic [WORD_W-1:0] mul_a;
   logic [WORD_W-1:0] mul_p;

   always_comb begin
      base   = head_item.start ? head_item.start_val : h_ff;
      tail_x = (head_item.op == OP_TAIL) ? head_item.operand : '0;
      // One multiplier serves the word loop and the avalanche.
      mul_a  = (state_ff == BK_FIN) ? (h_ff ^ (h_ff >> FIN_SHIFT1)) : (base ^ tail_x);
      mul_p  = mul_a * MIX_MUL;

      state_in = state_ff;
      h_in     = h_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;

      unique case (state_ff)
         BK_RUN: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (head_item.op)
                  OP_FULL: h_in = mul_p ^ head_item.operand;
                  OP_TAIL: h_in = mul_p;
                  default: h_in = base;
               endcase
               if (head_item.last) begin
                  state_in = BK_FIN;
               end
            end
         end
         BK_FIN: begin
            h_in     = mul_p;
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp.valid    = rsp_valid_ff;
      rsp.hash_out = rsp_hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hash_ff <= h_ff ^ (h_ff >> FIN_SHIFT2);
      end
   end

   `MH2_ASSERT(a_back_emit_src, !$rose(rsp_valid_ff) || $past(state_ff == BK_EMIT))
   `MH2_ASSERT_NEXT(a_back_fin_emit, state_ff == BK_FIN, state_ff == BK_EMIT)

endmodule

`default_nettype wire

// ----- tb/murmur2_32_stream_hash_tb.sv -----
// Self-checking testbench for murmur2_32_stream_hash: a scoreboard class predicts
// every message hash, while plain tasks stream messages and write the seed register.
// Depends on mh2_pkg, mh2_if and the murmur2_32_stream_hash RTL.
`timescale 1ns / 100ps

module murmur2_32_stream_hash_tb;
   import mh2_pkg::*;

   localparam int FULL_WORD_BYTES = 4;
   localparam int RANDOM_BEATS    = 1950;
   localparam int PHASE_BEATS     = 250;
   localparam int HOLD_CYCLES     = 80;
   localparam int SETTLE_CYCLES   = 10;
   localparam int END_CYCLES      = 20;
   localparam int IDLE_LIMIT      = 2000;
   localparam int REPORT_LIMIT    = 10;

   class hash_scoreboard;
      bit [WORD_W-1:0] seed;
      bit [WORD_W-1:0] acc_hash;
      bit              msg_open;
      bit [WORD_W-1:0] expected_hashes[$];
      int              failures;

      function new();
         seed     = '0;
         acc_hash = '0;
         msg_open = 1'b0;
         failures = 0;
      endfunction

      function bit [WORD_W-1:0] mix_word(bit [WORD_W-1:0] h, bit [WORD_W-1:0] k);
         bit [WORD_W-1:0] kx;
         kx = k * MIX_MUL;
         kx = kx ^ (kx >> KEY_SHIFT);
         kx = kx * MIX_MUL;
         return (h * MIX_MUL) ^ kx;
      endfunction

      function bit [WORD_W-1:0] avalanche(bit [WORD_W-1:0] h);
         bit [WORD_W-1:0] hx;
         hx = h ^ (h >> FIN_SHIFT1);
         hx = hx * MIX_MUL;
         return hx ^ (hx >> FIN_SHIFT2);
      endfunction

      function void set_seed(bit [WORD_W-1:0] value);
         seed = value;
      endfunction

      function int pending();
         return expected_hashes.size();
      endfunction

      function void note_beat(bit [WORD_W-1:0] word, bit [VCNT_W-1:0] nvb, bit last,
                              bit [LEN_W-1:0] len);
         bit [WORD_W-1:0] h;
         bit [WORD_W-1:0] mask;
         int              cnt;
         if (!msg_open) begin
            acc_hash = seed ^ {1'b0, len};
            msg_open = 1'b1;
         end
         h = acc_hash;
         if (!last) begin
            acc_hash = mix_word(h, word);
            return;
         end
         // Counts above a full word saturate to a full-word mix.
         cnt = (nvb > FULL_WORD_BYTES) ? FULL_WORD_BYTES : int'(nvb);
         if (cnt == FULL_WORD_BYTES) begin
            h = mix_word(h, word);
         end else if (cnt != 0) begin
            mask = (32'd1 << (8 * cnt)) - 32'd1;
            h = (h ^ (word & mask)) * MIX_MUL;
         end
         h = avalanche(h);
         acc_hash = h;
         msg_open = 1'b0;
         expected_hashes.push_back(h);
      endfunction

      function void check_hash(bit [WORD_W-1:0] actual);
         bit [WORD_W-1:0] want;
         if (expected_hashes.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected hash beat: hash_out=%08h", actual);
            return;
         end
         want = expected_hashes.pop_front();
         if (want !== actual) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("hash mismatch: expected %08h, got %08h", want, actual);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_en;
   logic [WORD_W-1:0] csr_write_data;

   mh2_req_if req_bus ();
   mh2_rsp_if rsp_bus ();

   murmur2_32_stream_hash uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus)
   );

   hash_scoreboard sb;
   int  beats_sent;
   int  idle_cycles;
   bit  sender_burst;
   bit  rsp_quiet;
   bit  hold_request;
   int  hold_left;
   int  stall_left;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   task automatic send_beat(input bit [WORD_W-1:0] word, input bit [VCNT_W-1:0] nvb,
                            input bit last, input bit [LEN_W-1:0] len, input int gap);
      @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.data_word   = word;
      req_bus.valid_bytes = nvb;
      req_bus.is_last     = last;
      req_bus.msg_length  = len;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_beat(word, nvb, last, len);
      beats_sent++;
      // With no gap, valid stays high and the next beat replaces the payload.
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic release_req();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Lets every hash out, then lets words still in flight settle.
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input bit [WORD_W-1:0] value);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = value;
      @(posedge clock);
      sb.set_seed(value);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic random_message();
      int              nbeats;
      int              r;
      bit [VCNT_W-1:0] tail;
      bit [LEN_W-1:0]  len;
      r = $urandom_range(0, 99);
      if (r < 45) nbeats = 1;
      else if (r < 85) nbeats = $urandom_range(2, 6);
      else if (r < 97) nbeats = $urandom_range(7, 16);
      else nbeats = $urandom_range(17, 48);
      tail = ($urandom_range(0, 99) < 80) ? VCNT_W'($urandom_range(0, 4))
                                          : VCNT_W'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 85)
         len = LEN_W'(FULL_WORD_BYTES * (nbeats - 1) +
                      ((tail > FULL_WORD_BYTES) ? FULL_WORD_BYTES : int'(tail)));
      else
         len = LEN_W'($urandom);
      for (int i = 0; i < nbeats; i++) begin
         if (i == nbeats - 1)
            send_beat(pick_word(), tail, 1'b1, len, sender_burst ? 0 : gap_len());
         else
            send_beat(pick_word(), VCNT_W'($urandom_range(0, 7)), 1'b0, len,
                      sender_burst ? 0 : gap_len());
      end
   endtask

   // Response side: random stalls, quiet stretches and one long hold-off.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (rsp_quiet || $urandom_range(0, 99) >= 25) begin
         rsp_bus.ready = 1'b1;
      end else begin
         rsp_bus.ready = 1'b0;
         stall_left    = gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_hash(rsp_bus.hash_out);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      bit [WORD_W-1:0] phase_seed;
      int              phase;
      int              random_start;
      sb                  = new();
      beats_sent          = 0;
      idle_cycles         = 0;
      sender_burst        = 1'b0;
      rsp_quiet           = 1'b0;
      hold_request        = 1'b0;
      hold_left           = 0;
      stall_left          = 0;
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.data_word   = '0;
      req_bus.valid_bytes = '0;
      req_bus.is_last     = 1'b0;
      req_bus.msg_length  = '0;
      rsp_bus.ready       = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset seed: empty message, every tail size,
      // and counts above a full word.
      send_beat('1, 3'd0, 1'b1, 31'd0, 0);
      for (int n = 1; n <= 7; n++)
         send_beat((n < FULL_WORD_BYTES) ? '1 : 32'hdeadbeef, VCNT_W'(n), 1'b1,
                   LEN_W'(n), 1);
      release_req();
      drain();
      write_seed('1);
      // Multi-word message whose non-last counts must be ignored.
      send_beat(32'h01234567, 3'd0, 1'b0, 31'd10, 0);
      send_beat(32'h89abcdef, 3'd7, 1'b0, 31'd10, 0);
      send_beat(32'hffffffff, 3'd2, 1'b1, 31'd10, 2);
      // Length field that disagrees with the words actually streamed.
      send_beat(32'h55555555, 3'd5, 1'b0, 31'h7fffffff, 0);
      send_beat(32'haaaaaaaa, 3'd4, 1'b1, 31'h7fffffff, 0);
      send_beat('0, 3'd4, 1'b1, 31'd0, 0);
      // Seed change while a message is open only applies to the next message.
      send_beat(32'hcafef00d, 3'd1, 1'b0, 31'd11, 0);
      send_beat(32'h0badc0de, 3'd3, 1'b0, 31'd11, 0);
      release_req();
      drain();
      write_seed(32'h9e3779b9);
      send_beat(32'h00fedcba, 3'd3, 1'b1, 31'd11, 0);
      send_beat(32'h13572468, 3'd4, 1'b1, 31'd4, 0);
      release_req();
      drain();

      random_start = beats_sent;
      phase        = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         case (phase % 6)
            0: phase_seed = '0;
            1: phase_seed = '1;
            2: phase_seed = 32'h80000000;
            3: phase_seed = 32'h00000001;
            default: phase_seed = $urandom;
         endcase
         write_seed(phase_seed);
         sender_burst = (phase % 3 == 2);
         rsp_quiet    = (phase % 4 == 3);
         if (phase == 1)
            hold_request = 1'b1;
         while ((beats_sent - random_start < RANDOM_BEATS) &&
                (beats_sent - random_start < (phase + 1) * PHASE_BEATS))
            random_message();
         release_req();
         drain();
         phase++;
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/mh2_pkg.sv
design/mh2_if.sv
design/mh2_front.sv
design/mh2_queue.sv
design/mh2_back.sv
design/murmur2_32_stream_hash.sv
tb/murmur2_32_stream_hash_tb.sv
